>>> rtl/sliding_window_bandwidth_meter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window bandwidth meter
// Clocked concurrent checks; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_BANDWIDTH_METER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_BANDWIDTH_METER_TOP_ASSERT_SVH

`ifndef SYNTH
// property holds at every clock edge out of reset
`define SWBM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition never seen at a clock edge out of reset
`define SWBM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SWBM_ASSERT(label, clk, rst_n, prop, msg)
`define SWBM_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/swbm_pkg.sv
// ----------------------------------------------------------------------------
// swbm_pkg
// Shared types and constants of the sliding window bandwidth meter.
// ----------------------------------------------------------------------------
package swbm_pkg;

  localparam int TIME_W      = 32;
  localparam int BYTE_IN_W   = 16;
  localparam int BYTES_W     = 32;
  localparam int SUM_W       = 40;
  localparam int WIN_W       = 16;
  localparam int USAGE_W     = 48;
  localparam int CNT_OUT_W   = 7;
  localparam int MS_PER_SEC  = 1000;
  localparam int MSEC_W      = $clog2(MS_PER_SEC);
  localparam int PROD_W      = SUM_W + MSEC_W;

  localparam int IN_TDATA_W  = TIME_W + BYTE_IN_W;
  localparam int OUT_TDATA_W = USAGE_W + 1 + CNT_OUT_W;

  localparam logic [WIN_W-1:0] WINDOW_MS_RST = WIN_W'(1000);
  localparam logic [WIN_W-1:0] BUCKET_MS_RST = WIN_W'(100);

  // divider retires this many quotient bits per cycle
  localparam int DIV_BITS   = 2;
  localparam int DIV_STEPS  = SUM_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_MS = 1'b0,
    REG_BUCKET_MS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // one bucket of the ring
  typedef struct packed {
    logic [TIME_W-1:0]  start;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/swbm_ring_mem.sv
// ----------------------------------------------------------------------------
// swbm_ring_mem
// Bucket ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swbm_ring_mem #(
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output swbm_pkg::entry_t      rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  swbm_pkg::entry_t      wr_data
);

  swbm_pkg::entry_t mem_r [DEPTH];
  swbm_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/swbm_div.sv
// ----------------------------------------------------------------------------
// swbm_div
// Iterative restoring divider, window sum by window length, two bits a cycle.
// ----------------------------------------------------------------------------
module swbm_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [swbm_pkg::SUM_W-1:0]        dividend,
  input  logic [swbm_pkg::WIN_W-1:0]        divisor,
  output logic [swbm_pkg::SUM_W-1:0]        quotient,
  output swbm_pkg::div_stat_t               stat
);

  logic [swbm_pkg::SUM_W-1:0]     quo_r;
  logic [swbm_pkg::WIN_W-1:0]     rem_r;
  logic [swbm_pkg::WIN_W-1:0]     div_r;
  logic [swbm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [swbm_pkg::SUM_W-1:0]     quo_nxt;
  logic [swbm_pkg::WIN_W-1:0]     rem_nxt;

  // two restoring steps; remainder stays below the divisor
  always_comb begin
    logic [swbm_pkg::WIN_W:0]   trial;
    logic [swbm_pkg::WIN_W-1:0] rem_v;
    logic [swbm_pkg::SUM_W-1:0] quo_v;
    rem_v = rem_r;
    quo_v = quo_r;
    trial = '0;
    for (int k = 0; k < swbm_pkg::DIV_BITS; k++) begin
      trial = {rem_v, quo_v[swbm_pkg::SUM_W-1]};
      quo_v = {quo_v[swbm_pkg::SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial    = trial - {1'b0, div_r};
        quo_v[0] = 1'b1;
      end
      rem_v = trial[swbm_pkg::WIN_W-1:0];
    end
    rem_nxt = rem_v;
    quo_nxt = quo_v;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= swbm_pkg::DIV_CNT_W'(swbm_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/sliding_window_bandwidth_meter_top.sv
// ----------------------------------------------------------------------------
// sliding_window_bandwidth_meter_top
// Byte-rate meter over a sliding window of millisecond time buckets.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per packet record (tuser = 0) or usage query
//           (tuser = 1); tdata carries time_now and byte_count.
//   out_* : exactly one transaction per input, in input order: usage in
//           bytes/s (zero for records), overflow flag, buckets held.
//   cfg_* : window_ms (index 0) and bucket_ms (index 1); write only while
//           the meter is idle. cfg_ready is always high.
// Sequencing (one item in flight at a time):
//   record : read the newest bucket on accept, then write it back.
//   query  : a walk over the held buckets, at most BUCKET_DEPTH, issuing one
//            read per held bucket on the single memory read port, then the
//            divider, which retires 2 bits a cycle.
// Reset: ring empty, window_ms = 1000, bucket_ms = 100. Bucket memory is not
//   cleared; entries are only read once written.
// Stall: a finished result sits in the output register; the next input is
//   accepted meanwhile and its result waits until the register drains.
// ----------------------------------------------------------------------------
`include "sliding_window_bandwidth_meter_top_assert.svh"

module sliding_window_bandwidth_meter_top #(
  parameter int BUCKET_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [swbm_pkg::IN_TDATA_W-1:0]       in_tdata,  // time_now[31:0], byte_count[47:32]
  input  logic                                  in_tuser,  // opcode[0]
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [swbm_pkg::OUT_TDATA_W-1:0]      out_tdata, // usage[47:0], overflow[48],
                                                           // bucket_count[55:49]
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swbm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swbm_pkg::WIN_W-1:0]            cfg_data
);

  localparam int AW = $clog2(BUCKET_DEPTH);
  localparam int CW = $clog2(BUCKET_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_WR,
    ST_Q_WALK,
    ST_Q_DIV,
    ST_Q_MUL,
    ST_DONE
  } state_t;

  // control state
  state_t                           state_r, state_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [CW-1:0]                    held_r, held_nxt;
  logic [AW-1:0]                    oldest_r, oldest_nxt;
  logic [swbm_pkg::WIN_W-1:0]       win_r, win_nxt;
  logic [swbm_pkg::WIN_W-1:0]       bkt_r, bkt_nxt;
  logic [CW-1:0]                    left_r, left_nxt;   // walk reads still to issue
  logic                             dv_r, dv_nxt;       // walk read data valid
  logic                             exp_r, exp_nxt;     // still expiring from the old end

  // payload
  logic [swbm_pkg::TIME_W-1:0]      now_r, now_nxt;
  logic [swbm_pkg::BYTE_IN_W-1:0]   bytes_r, bytes_nxt;
  logic [AW-1:0]                    rp_r, rp_nxt;
  logic [swbm_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [swbm_pkg::USAGE_W-1:0]     usage_r, usage_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [swbm_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // memory and divider hookup
  logic                             mem_rd_en;
  logic [AW-1:0]                    mem_rd_addr;
  swbm_pkg::entry_t                 mem_rd_data;
  logic                             mem_wr_en;
  logic [AW-1:0]                    mem_wr_addr;
  swbm_pkg::entry_t                 mem_wr_data;
  logic                             div_start;
  logic [swbm_pkg::SUM_W-1:0]       div_quo;
  swbm_pkg::div_stat_t              div_stat;

  // derived values
  logic [AW-1:0]                    newest_pos;
  logic [AW-1:0]                    tail_pos;
  logic [swbm_pkg::WIN_W-1:0]       win_eff;
  logic [swbm_pkg::TIME_W-1:0]      age;
  logic                             young;
  logic                             expired;
  logic                             full;
  logic [swbm_pkg::BYTES_W:0]       bkt_add;
  logic [swbm_pkg::SUM_W:0]         sum_add;
  logic [swbm_pkg::PROD_W-1:0]      prod;

  // ring position offset places after the oldest bucket
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(off);
    if (s >= (AW+1)'(BUCKET_DEPTH)) begin
      s = s - (AW+1)'(BUCKET_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(BUCKET_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign newest_pos = ring_pos(oldest_r, held_r - 1'b1);
  assign tail_pos   = ring_pos(oldest_r, held_r);
  assign win_eff    = (win_r == '0) ? swbm_pkg::WIN_W'(1) : win_r;
  assign full       = (held_r == CW'(BUCKET_DEPTH));

  // modular age; negative age is younger than any span and never expires
  assign age     = now_r - mem_rd_data.start;
  assign young   = age[swbm_pkg::TIME_W-1] ||
                   (age < swbm_pkg::TIME_W'(bkt_r));
  assign expired = !age[swbm_pkg::TIME_W-1] &&
                   (age > swbm_pkg::TIME_W'(win_eff));

  assign bkt_add = {1'b0, mem_rd_data.bytes} + (swbm_pkg::BYTES_W+1)'(bytes_r);
  assign sum_add = {1'b0, sum_r} + (swbm_pkg::SUM_W+1)'(mem_rd_data.bytes);
  assign prod    = swbm_pkg::PROD_W'(div_quo) * swbm_pkg::PROD_W'(swbm_pkg::MS_PER_SEC);

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    held_nxt      = held_r;
    oldest_nxt    = oldest_r;
    win_nxt       = win_r;
    bkt_nxt       = bkt_r;
    left_nxt      = left_r;
    dv_nxt        = dv_r;
    exp_nxt       = exp_r;
    now_nxt       = now_r;
    bytes_nxt     = bytes_r;
    rp_nxt        = rp_r;
    sum_nxt       = sum_r;
    usage_nxt     = usage_r;
    ovf_nxt       = ovf_r;
    out_data_nxt  = out_data_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = rp_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = newest_pos;
    mem_wr_data   = mem_rd_data;
    div_start     = 1'b0;

    if (cfg_valid) begin
      unique case (swbm_pkg::cfg_reg_t'(cfg_index))
        swbm_pkg::REG_WINDOW_MS: win_nxt = cfg_data;
        swbm_pkg::REG_BUCKET_MS: bkt_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          now_nxt   = in_tdata[swbm_pkg::TIME_W-1:0];
          bytes_nxt = in_tdata[swbm_pkg::IN_TDATA_W-1:swbm_pkg::TIME_W];
          ovf_nxt   = 1'b0;
          if (swbm_pkg::op_t'(in_tuser) == swbm_pkg::OP_RECORD) begin
            // fetch the newest bucket; data lands for the write-back cycle
            mem_rd_en   = (held_r != '0);
            mem_rd_addr = newest_pos;
            state_nxt   = ST_REC_WR;
          end else begin
            rp_nxt    = oldest_r;
            left_nxt  = held_r;
            dv_nxt    = 1'b0;
            exp_nxt   = 1'b1;
            sum_nxt   = '0;
            state_nxt = ST_Q_WALK;
          end
        end
      end

      ST_REC_WR: begin
        usage_nxt = '0;
        mem_wr_en = 1'b1;
        if (held_r != '0 && (young || full)) begin
          // merge into newest bucket, saturating
          ovf_nxt           = !young;
          mem_wr_addr       = newest_pos;
          mem_wr_data.start = mem_rd_data.start;
          mem_wr_data.bytes = bkt_add[swbm_pkg::BYTES_W] ? '1 :
                              bkt_add[swbm_pkg::BYTES_W-1:0];
        end else begin
          mem_wr_addr       = tail_pos;
          mem_wr_data.start = now_r;
          mem_wr_data.bytes = swbm_pkg::BYTES_W'(bytes_r);
          held_nxt          = held_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end

      ST_Q_WALK: begin
        // reads issue one per cycle; each is judged the cycle after
        dv_nxt = 1'b0;
        if (left_r != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rp_r;
          rp_nxt      = ring_inc(rp_r);
          left_nxt    = left_r - 1'b1;
          dv_nxt      = 1'b1;
        end
        if (dv_r) begin
          if (exp_r && expired) begin
            oldest_nxt = ring_inc(oldest_r);
            held_nxt   = held_r - 1'b1;
          end else begin
            exp_nxt = 1'b0;
            sum_nxt = sum_add[swbm_pkg::SUM_W] ? '1 : sum_add[swbm_pkg::SUM_W-1:0];
          end
        end
        if (left_r == '0 && !dv_r) begin
          if (held_r == '0) begin
            oldest_nxt = '0;
          end
          div_start = 1'b1;
          state_nxt = ST_Q_DIV;
        end
      end

      ST_Q_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_Q_MUL;
        end
      end

      ST_Q_MUL: begin
        usage_nxt = (prod[swbm_pkg::PROD_W-1:swbm_pkg::USAGE_W] != '0) ? '1 :
                    prod[swbm_pkg::USAGE_W-1:0];
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // hand off once the output register is free or draining
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {swbm_pkg::CNT_OUT_W'(held_r), ovf_r, usage_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    bytes_r    <= bytes_nxt;
    rp_r       <= rp_nxt;
    sum_r      <= sum_nxt;
    usage_r    <= usage_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      oldest_r    <= '0;
      win_r       <= swbm_pkg::WINDOW_MS_RST;
      bkt_r       <= swbm_pkg::BUCKET_MS_RST;
      left_r      <= '0;
      dv_r        <= 1'b0;
      exp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
      oldest_r    <= oldest_nxt;
      win_r       <= win_nxt;
      bkt_r       <= bkt_nxt;
      left_r      <= left_nxt;
      dv_r        <= dv_nxt;
      exp_r       <= exp_nxt;
    end
  end

  // accesses to the ring never overlap in a cycle, so no forwarding is needed:
  // a write always lands before the next read is issued
  swbm_ring_mem #(
    .DEPTH (BUCKET_DEPTH)
  ) u_ring_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  swbm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (win_eff),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  `SWBM_ASSERT(a_held_bound, clk, rst_n, held_r <= CW'(BUCKET_DEPTH), "held count above depth")
  `SWBM_ASSERT(a_oldest_bound, clk, rst_n, oldest_r <= AW'(BUCKET_DEPTH - 1), "oldest index out of ring")
  `SWBM_ASSERT(a_empty_origin, clk, rst_n, (state_r == ST_IDLE && held_r == '0) |-> oldest_r == '0, "empty ring not rewound")
  `SWBM_ASSERT_NEVER(a_rw_overlap, clk, rst_n, mem_rd_en && mem_wr_en, "ring read and write in one cycle")
  `SWBM_ASSERT(a_div_start_idle, clk, rst_n, div_start |-> !div_stat.busy, "divider restarted while busy")

endmodule
